// File: rtl/core/avgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avgp_pkg: shared types for the averaged perceptron trainer
// Beat layouts, op codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package avgp_pkg;

  localparam int NFEAT   = 8;
  localparam int SCORE_W = 56;
  localparam int DIV_W   = 64;

  // op codes of an input beat
  localparam logic [1:0] OP_TRAIN   = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  // register map (byte address bit 2 selects the register)
  localparam logic REG_AVG_MODE = 1'b0;
  localparam logic REG_FEATURES = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic               label_negative;
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic signed [15:0] x2;
    logic signed [15:0] x3;
    logic signed [15:0] x4;
    logic signed [15:0] x5;
    logic signed [15:0] x6;
    logic signed [15:0] x7;
  } in_beat_t;

  typedef struct packed {
    logic signed [55:0] score;
    logic               mistake;
    logic [23:0]        samples_seen;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_DACC,
    ST_SCORE,
    ST_UPD,
    ST_CACC,
    ST_DLOAD,
    ST_DSTEP,
    ST_DAPPLY,
    ST_DONE
  } state_e;

endpackage

// File: rtl/core/averaged_perceptron_trainer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaged_perceptron_trainer: online perceptron with weight averaging
// One shared multiplier and a bit-serial divider run under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid_i/in_ready_o | in_data_i  (in_beat_t)
//  out      | output    | out_valid_o/out_ready_i | out_data_o (out_beat_t)
//  cfg      | input     | APB psel/penable      | pwdata/prdata
//
//  predict: a multiply-accumulate per feature in use (shared multiplier);
//  a train mistake updates the weights and bias (and caches when averaged);
//  finish runs the one-bit-a-cycle divider per used weight and the bias.
//  in_ready_o is high only while the sequencer is idle; one item at a time.
//  a result waits in the output register; the block stalls only if a second
//  result is ready before the first is taken. reset clears all state at once.
module averaged_perceptron_trainer
  import avgp_pkg::*;
#(
  parameter int DIM        = 8,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(DIM + 1);
  localparam int AW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CB    = COUNT_BITS;
  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  // configuration
  logic       avg_q;
  logic [3:0] fiu_q;

  // trained state
  logic signed [31:0] w_q  [DIM];
  logic signed [31:0] b_q;
  logic signed [63:0] cw_q [DIM];
  logic signed [47:0] cb_q;
  logic [CB-1:0]      cnt_q;

  // item registers
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, n_q;
  logic [1:0]         op_q;
  logic               neg_q;
  logic signed [15:0] x_q [DIM];
  logic signed [SCORE_W-1:0] acc_q;
  logic signed [49:0] prod_q;
  logic               mist_q;

  // divider registers
  logic [CB:0]        rem_q;
  logic [DIV_W-1:0]   quo_q;
  logic               dneg_q;
  logic [STEP_W-1:0]  step_q;

  // result register
  out_beat_t          out_q;
  logic               out_valid_q;

  logic in_fire, out_fire, cfg_wr, can_load, more, wrong;
  logic signed [15:0] feat [NFEAT];
  logic [AW-1:0]      ia;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign cfg_wr   = psel && penable && pwrite;
  assign can_load = !out_valid_q || out_ready_i;
  assign ia       = idx_q[AW-1:0];
  assign more     = idx_q < n_q;
  assign wrong    = neg_q ? (acc_q >= 0) : (acc_q <= 0);

  assign feat[0] = in_data_i.x0;
  assign feat[1] = in_data_i.x1;
  assign feat[2] = in_data_i.x2;
  assign feat[3] = in_data_i.x3;
  assign feat[4] = in_data_i.x4;
  assign feat[5] = in_data_i.x5;
  assign feat[6] = in_data_i.x6;
  assign feat[7] = in_data_i.x7;

  // label times feature, 17 bits so that minus -32768 fits
  logic signed [16:0] lx;
  assign lx = neg_q ? -17'(x_q[ia]) : 17'(x_q[ia]);

  // shared multiplier: w*x while scoring, c*(label*x) while updating
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  always_comb begin
    if (state_q == ST_DOT) begin
      mul_a = 33'(w_q[ia]);
      mul_b = 17'(x_q[ia]);
    end else begin
      mul_a = signed'({{(33-CB){1'b0}}, cnt_q});
      mul_b = lx;
    end
  end
  assign mul_p = mul_a * mul_b;

  // weight plus label*x, saturated
  logic signed [32:0] wsum;
  logic signed [31:0] wsat;
  assign wsum = 33'(w_q[ia]) + 33'(lx);
  assign wsat = (wsum[32] != wsum[31]) ? {wsum[32], {31{~wsum[32]}}} : wsum[31:0];

  // cached weight plus product, saturated at 64 bits
  logic signed [64:0] csum;
  logic signed [63:0] csat;
  assign csum = 65'(cw_q[ia]) + 65'(prod_q);
  assign csat = (csum[64] != csum[63]) ? {csum[64], {63{~csum[64]}}} : csum[63:0];

  // bias plus label*256 and cached bias plus label*256*c
  logic signed [32:0] bsum;
  logic signed [31:0] bsat;
  logic signed [48:0] cbinc, cbsum;
  logic signed [47:0] cbsat;
  assign bsum  = 33'(b_q) + (neg_q ? -33'sd256 : 33'sd256);
  assign bsat  = (bsum[32] != bsum[31]) ? {bsum[32], {31{~bsum[32]}}} : bsum[31:0];
  assign cbinc = neg_q ? -signed'(49'({cnt_q, 8'h00})) : signed'(49'({cnt_q, 8'h00}));
  assign cbsum = 49'(cb_q) + cbinc;
  assign cbsat = (cbsum[48] != cbsum[47]) ? {cbsum[48], {47{~cbsum[48]}}} : cbsum[47:0];

  // divider dividend select and one restoring step
  logic signed [63:0] dvd;
  logic [CB:0]        rtry;
  logic               qbit;
  assign dvd  = more ? cw_q[ia] : 64'(cb_q);
  assign rtry = {rem_q[CB-1:0], quo_q[DIV_W-1]};
  assign qbit = rtry >= {1'b0, cnt_q};

  // quotient clamped to 2^33, then subtracted with saturation
  logic [33:0]        qmag;
  logic signed [34:0] qs;
  logic signed [35:0] asub;
  logic signed [31:0] osrc, asat;
  assign qmag = (quo_q > DIV_W'(34'h2_0000_0000)) ? 34'h2_0000_0000 : quo_q[33:0];
  assign qs   = dneg_q ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
  assign osrc = more ? w_q[ia] : b_q;
  assign asub = 36'(osrc) - 36'(qs);
  assign asat = (asub[35:31] != {5{asub[35]}}) ? {asub[35], {31{~asub[35]}}} : asub[31:0];

  // counter after a train item
  logic [CB-1:0] cnt_upd;
  assign cnt_upd = (op_q == OP_TRAIN && avg_q && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = (in_data_i.op == OP_FINISH) ? ST_DLOAD : ST_DOT;
      ST_DOT:    state_d = more ? ST_DACC : ST_SCORE;
      ST_DACC:   state_d = ST_DOT;
      ST_SCORE:  state_d = (op_q == OP_TRAIN && wrong) ? ST_UPD : ST_DONE;
      ST_UPD:    state_d = more ? (avg_q ? ST_CACC : ST_UPD) : ST_DONE;
      ST_CACC:   state_d = ST_UPD;
      ST_DLOAD:  state_d = ST_DSTEP;
      ST_DSTEP:  if (step_q == STEP_LAST) state_d = ST_DAPPLY;
      ST_DAPPLY: state_d = more ? ST_DLOAD : ST_DONE;
      ST_DONE:   if (can_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= 1'b0;
      fiu_q <= 4'd8;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_AVG_MODE) avg_q <= pwdata[0];
      else fiu_q <= pwdata[3:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FEATURES) ? {28'h0, fiu_q} : {31'h0, avg_q};

  // datapath and trained state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIM; i++) begin
        w_q[i]  <= '0;
        cw_q[i] <= '0;
        x_q[i]  <= '0;
      end
      b_q         <= '0;
      cb_q        <= '0;
      cnt_q       <= CB'(1);
      idx_q       <= '0;
      n_q         <= '0;
      op_q        <= OP_PREDICT;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      prod_q      <= '0;
      mist_q      <= 1'b0;
      rem_q       <= '0;
      quo_q       <= '0;
      dneg_q      <= 1'b0;
      step_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // taken beat clears valid unless a new result loads in its place
      if (out_fire && !(state_q == ST_DONE && can_load)) out_valid_q <= 1'b0;
      unique case (state_q)
        // latch the beat and seed the score with the bias
        ST_IDLE: begin
          if (in_fire) begin
            op_q   <= in_data_i.op;
            neg_q  <= in_data_i.label_negative;
            for (int i = 0; i < DIM; i++) x_q[i] <= feat[i];
            n_q    <= (32'(fiu_q) > DIM) ? IDX_W'(DIM) : IDX_W'(fiu_q);
            idx_q  <= '0;
            mist_q <= 1'b0;
            acc_q  <= SCORE_W'(signed'({b_q, 8'h00}));
          end
        end
        ST_DOT: begin
          if (more) prod_q <= mul_p;
        end
        // sum stays well inside 56 bits, so no clamp is needed
        ST_DACC: begin
          acc_q <= acc_q + SCORE_W'(prod_q);
          idx_q <= idx_q + 1'b1;
        end
        ST_SCORE: begin
          idx_q <= '0;
          if (op_q == OP_TRAIN && wrong) mist_q <= 1'b1;
        end
        ST_UPD: begin
          if (more) begin
            w_q[ia] <= wsat;
            if (avg_q) prod_q <= mul_p;
            else idx_q <= idx_q + 1'b1;
          end else begin
            b_q <= bsat;
            if (avg_q) cb_q <= cbsat;
          end
        end
        ST_CACC: begin
          cw_q[ia] <= csat;
          idx_q    <= idx_q + 1'b1;
        end
        // start one division of a cached sum by the counter
        ST_DLOAD: begin
          dneg_q <= dvd[63];
          quo_q  <= dvd[63] ? DIV_W'(-dvd) : DIV_W'(dvd);
          rem_q  <= '0;
          step_q <= '0;
        end
        ST_DSTEP: begin
          rem_q  <= qbit ? rtry - {1'b0, cnt_q} : rtry;
          quo_q  <= {quo_q[DIV_W-2:0], qbit};
          step_q <= step_q + 1'b1;
        end
        ST_DAPPLY: begin
          if (more) begin
            w_q[ia] <= asat;
            idx_q   <= idx_q + 1'b1;
          end else begin
            b_q <= asat;
          end
        end
        // publish the result and commit the counter; finish resets it and the caches
        ST_DONE: begin
          if (can_load) begin
            out_valid_q <= 1'b1;
            if (op_q == OP_FINISH) begin
              for (int i = 0; i < DIM; i++) cw_q[i] <= '0;
              cb_q               <= '0;
              cnt_q              <= CB'(1);
              out_q.score        <= '0;
              out_q.mistake      <= 1'b0;
              out_q.samples_seen <= 24'd1;
            end else begin
              cnt_q              <= cnt_upd;
              out_q.score        <= acc_q;
              out_q.mistake      <= mist_q;
              out_q.samples_seen <= 24'(cnt_upd);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/avgp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avgp_checker: port-level checks for the averaged perceptron trainer
// Watches the beat handshakes and the one-item-at-a-time sequencing.
// ----------------------------------------------------------------------------
module avgp_checker
  import avgp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_data_o
);

  // sequencer is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o high right after an input beat");

  // no result appears in the cycle after a beat is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after input beat");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  // a sampled reset clears out_valid_o
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("out_valid_o high after reset");

endmodule

bind averaged_perceptron_trainer avgp_checker u_avgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the averaged perceptron trainer
// Drives train, predict and finish beats under random gaps and output stalls.
// A local predictor tracks the weights, bias, caches and counter, and every
// output beat is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import avgp_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [2:0] ADDR_AVG_MODE = 3'd0;
  localparam logic [2:0] ADDR_FEATURES = 3'd4;
  localparam longint     S56_MAX = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint     S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint     S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint     L_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint     L_MIN   = -L_MAX - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  averaged_perceptron_trainer u_top (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  longint    wgt[8], wsum[8];
  longint    bias_q, bias_sum, seen_cnt;
  bit        avg_on;
  int        feat_cnt;
  out_beat_t score_q[$];
  int        errors = 0;
  bit        hold_rx = 1'b0;
  bit        no_gaps = 1'b0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint add_sat(longint a, longint d);
    if (d > 0 && a > L_MAX - d) return L_MAX;
    if (d < 0 && a < L_MIN - d) return L_MIN;
    return a + d;
  endfunction

  // one beat through the trainer model
  function automatic out_beat_t train_step(in_beat_t it);
    longint    xs[8];
    longint    s, lab, c, q;
    bit        wrong;
    int        n;
    out_beat_t r;
    xs[0] = $signed(it.x0); xs[1] = $signed(it.x1);
    xs[2] = $signed(it.x2); xs[3] = $signed(it.x3);
    xs[4] = $signed(it.x4); xs[5] = $signed(it.x5);
    xs[6] = $signed(it.x6); xs[7] = $signed(it.x7);
    n = feat_cnt < 8 ? feat_cnt : 8;
    lab = it.label_negative ? -1 : 1;
    s = 0;
    r = '0;
    if (it.op == OP_FINISH) begin
      c = seen_cnt < 1 ? 1 : seen_cnt;
      for (int i = 0; i < n; i++) begin
        q = clamp(wsum[i] / c, -(64'sd1 <<< 33), 64'sd1 <<< 33);
        wgt[i] = clamp(wgt[i] - q, -S32_MAX - 1, S32_MAX);
      end
      bias_q = clamp(bias_q - bias_sum / c, -S32_MAX - 1, S32_MAX);
      for (int i = 0; i < 8; i++) wsum[i] = 0;
      bias_sum = 0;
      seen_cnt = 1;
    end else begin
      for (int i = 0; i < n; i++) s += wgt[i] * xs[i];
      s = clamp(s + bias_q * 256, -S56_MAX - 1, S56_MAX);
      if (it.op == OP_TRAIN) begin
        wrong = lab > 0 ? (s <= 0) : (s >= 0);
        c = seen_cnt;
        if (wrong) begin
          r.mistake = 1'b1;
          for (int i = 0; i < n; i++) begin
            wgt[i] = clamp(wgt[i] + lab * xs[i], -S32_MAX - 1, S32_MAX);
            if (avg_on) wsum[i] = add_sat(wsum[i], lab * xs[i] * c);
          end
          bias_q = clamp(bias_q + lab * 256, -S32_MAX - 1, S32_MAX);
          if (avg_on) bias_sum = clamp(bias_sum + lab * 256 * c, -S48_MAX - 1, S48_MAX);
        end
        if (avg_on && seen_cnt < 64'h00FF_FFFF) seen_cnt++;
      end
    end
    r.score = s[55:0];
    r.samples_seen = seen_cnt[23:0];
    return r;
  endfunction

  task automatic report(string fld, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", fld, got, want, $realtime);
    errors++;
  endtask

  // output beat checker
  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (score_q.size() == 0) begin
        report("unexpected beat", out_data_o.score, 0);
      end else begin
        e = score_q.pop_front();
        if (out_data_o.score !== e.score) report("score", out_data_o.score, e.score);
        if (out_data_o.mistake !== e.mistake) report("mistake", out_data_o.mistake, e.mistake);
        if (out_data_o.samples_seen !== e.samples_seen)
          report("samples_seen", out_data_o.samples_seen, e.samples_seen);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 99) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // receiver: ready bursts with mostly short stalls
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 20);
      repeat (run) begin
        @(negedge clk_i);
        out_ready_i <= hold_rx ? 1'b0 : 1'b1;
      end
      run = pick_gap();
      repeat (run) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
    end
  end

  task automatic send_item(in_beat_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    score_q.push_back(train_step(it));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_AVG_MODE) avg_on = val[0];
    else feat_cnt = 32'(val[3:0]);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_mode(bit avg, int n);
    drain();
    cfg_write(ADDR_AVG_MODE, 32'(avg));
    cfg_write(ADDR_FEATURES, 32'(n));
  endtask

  function automatic logic [15:0] rand_feat();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'h0001;
        default: return 16'hFFFF;
      endcase
    end
    if (p < 4) return 16'($signed($urandom_range(0, 1024)) - 512);
    return 16'($urandom);
  endfunction

  function automatic in_beat_t mk_item(logic [1:0] op, logic neg, logic [15:0] v);
    in_beat_t it;
    it.op = op; it.label_negative = neg;
    it.x0 = v; it.x1 = v; it.x2 = v; it.x3 = v;
    it.x4 = v; it.x5 = v; it.x6 = v; it.x7 = v;
    return it;
  endfunction

  function automatic in_beat_t rand_item();
    in_beat_t it;
    int p;
    p = $urandom_range(0, 99);
    it.op = p < 85 ? OP_TRAIN : (p < 96 ? OP_PREDICT : (p < 98 ? OP_FINISH : OP_UNUSED));
    it.label_negative = 1'($urandom_range(0, 1));
    it.x0 = rand_feat(); it.x1 = rand_feat(); it.x2 = rand_feat(); it.x3 = rand_feat();
    it.x4 = rand_feat(); it.x5 = rand_feat(); it.x6 = rand_feat(); it.x7 = rand_feat();
    return it;
  endfunction

  // extremes, every op, finish in plain mode and the unused op code
  task automatic test_directed();
    set_mode(1'b0, 8);
    send_item(mk_item(OP_PREDICT, 1'b0, 16'h0000));
    send_item(mk_item(OP_TRAIN, 1'b0, 16'h7FFF));
    send_item(mk_item(OP_TRAIN, 1'b1, 16'h7FFF));
    send_item(mk_item(OP_TRAIN, 1'b1, 16'h8000));
    send_item(mk_item(OP_TRAIN, 1'b0, 16'h8000));
    send_item(mk_item(OP_PREDICT, 1'b1, 16'h7FFF));
    send_item(mk_item(OP_UNUSED, 1'b0, 16'h8000));
    send_item(mk_item(OP_FINISH, 1'b0, 16'h0000));
    set_mode(1'b1, 8);
    send_item(mk_item(OP_TRAIN, 1'b0, 16'h0001));
    send_item(mk_item(OP_TRAIN, 1'b1, 16'h7FFF));
    send_item(mk_item(OP_TRAIN, 1'b0, 16'h8000));
    send_item(mk_item(OP_TRAIN, 1'b1, 16'hFFFF));
    send_item(mk_item(OP_PREDICT, 1'b0, 16'h0100));
    send_item(mk_item(OP_FINISH, 1'b1, 16'h7FFF));
    send_item(mk_item(OP_PREDICT, 1'b0, 16'h0100));
    set_mode(1'b1, 1);
    send_item(mk_item(OP_TRAIN, 1'b1, 16'h7FFF));
    send_item(mk_item(OP_TRAIN, 1'b0, 16'h7FFF));
    send_item(mk_item(OP_FINISH, 1'b0, 16'h0000));
    // feature count zero and out of range
    set_mode(1'b1, 0);
    send_item(mk_item(OP_TRAIN, 1'b0, 16'h1234));
    send_item(mk_item(OP_FINISH, 1'b0, 16'h0000));
    set_mode(1'b1, 15);
    send_item(mk_item(OP_TRAIN, 1'b1, 16'h4321));
    send_item(mk_item(OP_FINISH, 1'b0, 16'h0000));
  endtask

  // random beats over a sweep of register settings
  task automatic test_config_sweep();
    bit avgs[7] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    int ns[7]   = '{8, 8, 1, 5, 3, 12, 8};
    for (int ph = 0; ph < 7; ph++) begin
      set_mode(avgs[ph], ns[ph]);
      no_gaps = (ph == 3);
      repeat (200) send_item(rand_item());
    end
    no_gaps = 1'b0;
  endtask

  // receiver held off while the sender keeps offering beats
  task automatic test_backpressure();
    set_mode(1'b1, 8);
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (30) send_item(rand_item());
    join
    drain();
    repeat (20) send_item(rand_item());
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      wgt[i] = 0; wsum[i] = 0;
    end
    bias_q = 0; bias_sum = 0; seen_cnt = 1; avg_on = 1'b0; feat_cnt = 8;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_config_sweep();
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && score_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(8 * 10_000_000);
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/core/avgp_pkg.sv
rtl/core/averaged_perceptron_trainer.sv
rtl/core/avgp_checker.sv
tb/sv/tb.sv
